// File: hdl/ldil_pkg.sv
package ldil_pkg;

    // Width of each configuration register and of the row position
    localparam int CFG_W        = 11;
    localparam int ROW_W        = 11;
    localparam int HEIGHT_LIMIT = 1024;

    typedef struct packed {
        logic [7:0] in_pixel;
        logic       flush_tick;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       out_last;
    } out_item_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic en;
        logic clr;
    } cell_ctrl_t;

endpackage

// File: hdl/ldil_cell.sv
module ldil_cell
    import ldil_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctrl_t                   ctrl,
    input  logic [2:0][PIXEL_BITS-1:0]   col_in,
    output logic [2:0][PIXEL_BITS-1:0]   col_out
);

    logic [2:0][PIXEL_BITS-1:0] col_reg;

    // Take the neighbor's column, or drop to zero at a row or frame boundary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.en)
        begin
            col_reg <= ctrl.clr ? '0 : col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// File: hdl/ldil_line_store.sv
module ldil_line_store
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic                          bank,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col,
    input  logic [PIXEL_BITS-1:0]         wdata,
    output logic [PIXEL_BITS-1:0]         top,
    output logic [PIXEL_BITS-1:0]         mid
);

    logic [PIXEL_BITS-1:0] mem0 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem1 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] top_reg;
    logic [PIXEL_BITS-1:0] mid_reg;

    // Bank 'bank' holds row y-2: read it before overwriting with row y
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (bank)
            begin
                top_reg   <= mem1[col];
                mid_reg   <= mem0[col];
                mem1[col] <= wdata;
            end
            else
            begin
                top_reg   <= mem0[col];
                mid_reg   <= mem1[col];
                mem0[col] <= wdata;
            end
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

// File: hdl/label_dilation_3x3.sv
// 3x3 label dilation over a raster-order pixel stream.
// Input channel pix_valid/pix_ready/pix_data carries one item per cycle: a
// pixel, or a flush tick (flush_tick = 1). Flush ticks that arrive while
// frame pixels are still expected are taken and dropped. After the last
// pixel of a frame, image_width + 1 further items (ticks or pixels, whose
// values are ignored) drain the final row.
// Output channel res_valid/res_ready/res_data carries the dilated pixels in
// raster order; out_last marks the final pixel of the frame.
// Throughput: one item per cycle while pix_ready is high. A pixel's result,
// set by the item image_width + 1 items later that completes its neighborhood,
// passes the stage-1 registers and the output register to res_valid.
// When the receiver stalls, an output register plus a skid register hold up
// to two results; only when both are full does pix_ready drop.
// The user writes configuration (cfg_we/cfg_index/cfg_data) only while idle;
// the block does not enforce it. Sizes are clamped to their legal range on
// write. Reset restores width 1024 (or MAX_WIDTH if smaller), height 1024 and
// a fresh frame. Buffers are not cleared; rows are always written before read.
module label_dilation_3x3
    import ldil_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  in_item_t          pix_data,
    output logic              res_valid,
    input  logic              res_ready,
    output out_item_t         res_data,
    input  logic              cfg_we,
    input  cfg_reg_t          cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CNT_W   = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
    localparam int RST_W   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int NCELLS  = 2;

    // ------------------------------------------------------------------
    // Dilation pick: center if nonzero, else first nonzero neighbor in
    // the order TL, T, TR, L, R, BL, B, BR. Column index 0 is top.
    // ------------------------------------------------------------------
    function automatic logic [PIXEL_BITS-1:0] pick(
        input logic [2:0][PIXEL_BITS-1:0] lc,
        input logic [2:0][PIXEL_BITS-1:0] cc,
        input logic [2:0][PIXEL_BITS-1:0] rc
    );
        logic [7:0][PIXEL_BITS-1:0] nb;
        logic [PIXEL_BITS-1:0]      res;
        nb[0] = lc[0];
        nb[1] = cc[0];
        nb[2] = rc[0];
        nb[3] = lc[1];
        nb[4] = rc[1];
        nb[5] = lc[2];
        nb[6] = cc[2];
        nb[7] = rc[2];
        res = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (nb[k] != '0)
            begin
                res = nb[k];
            end
        end
        if (cc[1] != '0)
        begin
            res = cc[1];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration: store clamped sizes, keep the pixel count of a frame
    // ------------------------------------------------------------------
    logic [CW-1:0]     width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [CNT_W-1:0]  area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(RST_W);
            height_reg <= ROW_W'(HEIGHT_LIMIT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_reg <= CW'(1);
                    else if (32'(cfg_data) > 32'(MAX_WIDTH))
                        width_reg <= CW'(MAX_WIDTH);
                    else
                        width_reg <= CW'(cfg_data);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_reg <= ROW_W'(1);
                    else if (32'(cfg_data) > 32'(HEIGHT_LIMIT))
                        height_reg <= ROW_W'(HEIGHT_LIMIT);
                    else
                        height_reg <= ROW_W'(cfg_data);
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_reg <= CNT_W'(RST_W * HEIGHT_LIMIT);
        else
            area_reg <= CNT_W'(width_reg) * CNT_W'(height_reg);
    end

    // ------------------------------------------------------------------
    // Stage 0: input position tracking, line-buffer access
    // ------------------------------------------------------------------
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              wrap, restart, drain, ignore;
    logic [CW-1:0]     col_a, col_b;
    logic [ROW_W-1:0]  row_a, row_b;
    logic [CNT_W-1:0]  count_b, count_inc;
    logic              x0, yge1, yge2, have, last;
    logic [PIXEL_BITS-1:0] pix_in;
    logic              accept, advance;

    // Wrap a column at or past the width, restart a frame past the drain rows
    always_comb
    begin
        wrap    = col_reg >= width_reg;
        col_a   = wrap ? '0 : col_reg;
        row_a   = wrap ? row_reg + ROW_W'(1) : row_reg;
        restart = row_a > (height_reg + ROW_W'(1));
        col_b   = restart ? '0 : col_a;
        row_b   = restart ? '0 : row_a;
        count_b = restart ? '0 : count_reg;

        drain   = row_b >= height_reg;
        ignore  = !drain && pix_data.flush_tick;
        pix_in  = drain ? '0 : PIXEL_BITS'(pix_data.in_pixel);

        x0      = col_b == '0;
        yge1    = row_b != '0;
        yge2    = row_b >= ROW_W'(2);
        have    = (x0 && yge2) || (!x0 && yge1);

        count_inc = count_b + CNT_W'(1);
        last      = have && ((count_inc >= area_reg) ||
                             (row_b == (height_reg + ROW_W'(1))));
    end

    assign accept  = pix_valid && pix_ready;
    assign advance = accept && !ignore;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (ignore)
            begin
                // Commit the normalized position only
                col_next   = col_b;
                row_next   = row_b;
                count_next = count_b;
            end
            else if (last)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
            end
            else
            begin
                col_next   = col_b + CW'(1);
                row_next   = row_b;
                count_next = have ? count_inc : count_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

    logic [PIXEL_BITS-1:0] top_rd, mid_rd;

    ldil_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .clk   (clk),
        .en    (advance),
        .bank  (row_b[0]),
        .col   (col_b[AW-1:0]),
        .wdata (pix_in),
        .top   (top_rd),
        .mid   (mid_rd)
    );

    // ------------------------------------------------------------------
    // Stage 1: window update in the cell chain, dilation, result push
    // ------------------------------------------------------------------
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_x0_reg, s1_yge1_reg, s1_yge2_reg;
    logic                  s1_have_reg, s1_last_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_fire;

    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    out_item_t             out_item_reg, out_item_next;
    out_item_t             skid_item_reg, skid_item_next;

    assign s1_fire   = s1_valid_reg && (!s1_have_reg || !skid_valid_reg);
    assign pix_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x0_reg   <= x0;
            s1_yge1_reg <= yge1;
            s1_yge2_reg <= yge2;
            s1_have_reg <= have;
            s1_last_reg <= last;
            s1_pix_reg  <= pix_in;
        end
    end

    // Incoming column: rows above the frame read as zero
    logic [2:0][PIXEL_BITS-1:0] new_col, right_col;
    logic [2:0][PIXEL_BITS-1:0] chain [NCELLS+1];
    logic [PIXEL_BITS-1:0]      dil_val;

    always_comb
    begin
        new_col[0] = s1_yge2_reg ? top_rd : '0;
        new_col[1] = s1_yge1_reg ? mid_rd : '0;
        new_col[2] = s1_pix_reg;
        // At column zero the result is the previous row's last pixel,
        // whose right neighbors lie outside the frame
        right_col  = s1_x0_reg ? '0 : new_col;
    end

    assign chain[NCELLS] = new_col;

    // chain[1] is the center column, chain[0] the left column
    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            assign ctrl = '{en:  s1_fire,
                            clr: (gi == NCELLS - 1) ? s1_last_reg
                                                    : (s1_x0_reg || s1_last_reg)};
            ldil_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .col_in  (chain[gi+1]),
                .col_out (chain[gi])
            );
        end
    endgenerate

    // Left and center are taken before the shift: at column zero they are
    // the previous row's last two columns, otherwise they become the left
    // and center of the shifted window.
    assign dil_val = pick(chain[0], chain[1], right_col);

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic      push, pop;
    out_item_t push_item;

    assign push                = s1_fire && s1_have_reg;
    assign pop                 = out_valid_reg && res_ready;
    assign push_item.out_pixel = 8'(dil_val);
    assign push_item.out_last  = s1_last_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_item_next = push_item;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_item_next  = push_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next  = push_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_item_reg;

endmodule

// File: dv/label_dilation_3x3_test.sv
module label_dilation_3x3_test;
    import ldil_pkg::*;

    // Sizes and knobs of the bench
    localparam int MAX_W          = 1024;
    localparam int HEIGHT_MAX     = 1024;
    localparam int STALL_PCT      = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int SETTLE_CYCLES  = 8;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             pix_valid = 1'b0;
    logic             pix_ready;
    in_item_t         pix_data  = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    out_item_t        res_data;
    logic             cfg_we    = 1'b0;
    cfg_reg_t         cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;

    // When set, neither side inserts bubbles
    bit steady = 1'b0;

    int bad_count    = 0;
    int items_in     = 0;
    int results_seen = 0;
    int frames_out   = 0;
    int idle_cycles  = 0;

    label_dilation_3x3 i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Dilation predictor: its own copy of the sizes, the two line buffers,
    // the 3x3 window and the frame position. It advances once per accepted
    // item and queues the dilated pixels that the item releases.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg  = 11'd1024;
    logic [CFG_W-1:0] height_reg = 11'd1024;
    logic [7:0]       line_mem [0:2*MAX_W-1];
    logic [7:0]       win [0:2][0:2];   // [top..bottom][oldest..newest column]
    logic [10:0]      col_pos;
    logic [10:0]      row_pos;
    logic [19:0]      emitted;          // pixels out so far in this frame
    out_item_t        dilated_q [$];

    // Pixels of the next frame to send
    logic [7:0]       frame_px [$];

    function automatic int eff_width();
        if (width_reg < 1)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg < 1)
            return 1;
        if (height_reg > HEIGHT_MAX)
            return HEIGHT_MAX;
        return height_reg;
    endfunction

    // Center wins if nonzero; otherwise first nonzero neighbor in raster
    // order (top-left, top, top-right, left, right, bottom row).
    function automatic logic [7:0] dilate_pick(input logic [8:0][7:0] nb);
        int k;
        if (nb[4] != 8'd0)
            return nb[4];
        for (k = 0; k < 9; k++)
        begin
            if (k != 4 && nb[k] != 8'd0)
                return nb[k];
        end
        return 8'd0;
    endfunction

    task automatic restart_frame();
        int r;
        int c;
        col_pos = '0;
        row_pos = '0;
        emitted = '0;
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                win[r][c] = 8'd0;
    endtask

    task automatic dilate_step(input in_item_t it);
        int               w;
        int               h;
        int               r;
        int               top_i;
        int               mid_i;
        logic [7:0]       px;
        logic [7:0]       val;
        logic [8:0][7:0]  nb;
        logic             have;
        logic             drain;
        logic             last_flag;
        logic [10:0]      x;
        logic [10:0]      y;
        out_item_t        res;

        w = eff_width();
        h = eff_height();
        if (col_pos >= w)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        // A row past the drain rows only happens after a height cut
        if (row_pos > h + 1)
            restart_frame();
        drain = (row_pos >= h);

        // Flush ticks during the pixel part of a frame are dropped
        if (drain || !it.flush_tick)
        begin
            px   = drain ? 8'd0 : it.in_pixel;
            y    = row_pos;
            x    = col_pos;
            have = 1'b0;
            val  = 8'd0;

            if (x == 0)
            begin
                // Row start closes the last pixel of row y-2: its right
                // column lies outside the frame.
                if (y >= 2)
                begin
                    for (r = 0; r < 3; r++)
                    begin
                        nb[r*3]   = win[r][1];
                        nb[r*3+1] = win[r][2];
                        nb[r*3+2] = 8'd0;
                    end
                    val  = dilate_pick(nb);
                    have = 1'b1;
                end
                for (r = 0; r < 3; r++)
                begin
                    win[r][0] = 8'd0;
                    win[r][1] = 8'd0;
                end
            end
            else
            begin
                for (r = 0; r < 3; r++)
                begin
                    win[r][0] = win[r][1];
                    win[r][1] = win[r][2];
                end
            end

            // Two line buffers, ping-ponged on the row parity
            top_i = (y[0] ? MAX_W : 0) + x;
            mid_i = (y[0] ? 0 : MAX_W) + x;
            win[0][2] = (y >= 2) ? line_mem[top_i] : 8'd0;
            win[1][2] = (y >= 1) ? line_mem[mid_i] : 8'd0;
            win[2][2] = px;
            line_mem[top_i] = px;

            if (x >= 1 && y >= 1)
            begin
                for (r = 0; r < 3; r++)
                begin
                    nb[r*3]   = win[r][0];
                    nb[r*3+1] = win[r][1];
                    nb[r*3+2] = win[r][2];
                end
                val  = dilate_pick(nb);
                have = 1'b1;
            end

            col_pos = col_pos + 1'b1;

            if (have)
            begin
                last_flag = (int'(emitted) + 1 >= w * h) || (y == h + 1);
                res.out_pixel = val;
                res.out_last  = last_flag;
                dilated_q.push_back(res);
                if (last_flag)
                    restart_frame();
                else
                    emitted = emitted + 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sample both channels at the rising edge: advance the predictor on
    // each accepted item, then check each accepted result against the
    // oldest pending dilated pixel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
            begin
                dilate_step(pix_data);
                items_in++;
            end
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (res_data.out_last)
                    frames_out++;
                if (dilated_q.size() == 0)
                begin
                    $error("unexpected result: out_pixel %0d out_last %0d",
                           res_data.out_pixel, res_data.out_last);
                    bad_count++;
                end
                else
                begin
                    want = dilated_q.pop_front();
                    if (res_data.out_pixel !== want.out_pixel)
                    begin
                        $error("out_pixel: expected %0d, actual %0d",
                               want.out_pixel, res_data.out_pixel);
                        bad_count++;
                    end
                    if (res_data.out_last !== want.out_last)
                    begin
                        $error("out_last: expected %0d, actual %0d",
                               want.out_last, res_data.out_last);
                        bad_count++;
                    end
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall at random unless in a steady stretch
    always @(negedge clk)
        res_ready <= steady || ($urandom_range(99) >= STALL_PCT);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // pix_ready as seen at the last rising edge
    logic pix_ready_seen = 1'b0;
    always @(posedge clk)
        pix_ready_seen <= pix_ready;

    // Present one item and hold it until accepted. Called at a falling
    // edge, returns at a falling edge with valid still high.
    task automatic send_item(input logic [7:0] px, input logic flush);
        if (!steady && $urandom_range(99) < STALL_PCT)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= {px, flush};
        do
            @(negedge clk);
        while (!(pix_valid && pix_ready_seen));
    endtask

    // Drop valid, wait for every pending pixel, then let the pipeline empty
    task automatic settle();
        pix_valid <= 1'b0;
        @(negedge clk);
        while (dilated_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Queue n pixels, density_pct of them nonzero
    task automatic fill_random(input int n, input int density_pct);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < density_pct)
                frame_px.push_back(8'($urandom_range(1, 255)));
            else
                frame_px.push_back(8'd0);
        end
    endtask

    // Send the queued pixels, with stray flush ticks mixed in at noise_pct,
    // then the drain items; pixels_pct of the drain items are pixels,
    // which the block must treat as flush ticks.
    task automatic push_frame(input int pixels_pct, input int noise_pct);
        int i;
        for (i = 0; i < frame_px.size(); i++)
        begin
            while ($urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b1);
            send_item(frame_px[i], 1'b0);
        end
        for (i = 0; i <= eff_width(); i++)
            send_item(8'($urandom_range(255)), ($urandom_range(99) >= pixels_pct));
        frame_px.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero center surrounded by distinct values: top-left must win
    task automatic test_neighbor_order();
        set_size(11'd3, 11'd3);
        frame_px = {8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd5, 8'd6, 8'd7, 8'd8};
        push_frame(0, 0);
    endtask

    // One seed in the bottom-right corner spreads up and left
    task automatic test_corner_seed();
        set_size(11'd2, 11'd2);
        frame_px = {8'd0, 8'd0, 8'd0, 8'd255};
        push_frame(100, 0);
    endtask

    // Flush ticks before the only pixel are dropped; drain items are pixels half the time
    task automatic test_flush_rules();
        set_size(11'd1, 11'd1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        frame_px = {8'h80};
        push_frame(50, 0);
    endtask

    // Height cut mid-frame: the next item wraps past the drain rows and
    // starts a fresh frame with the new height
    task automatic test_height_cut();
        int i;
        set_size(11'd4, 11'd6);
        for (i = 0; i < 16; i++)
            send_item(8'($urandom_range(255)), 1'b0);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        fill_random(eff_width() * eff_height(), 60);
        push_frame(30, 0);
    endtask

    // Mostly small frames with random content, some wider ones; the middle
    // stretch runs without bubbles on either side
    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int dens;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= RANDOM_ITEMS / 3) && (sent < RANDOM_ITEMS / 2);
            if ($urandom_range(9) == 0)
            begin
                w = $urandom_range(13, 80);
                h = $urandom_range(1, 3);
            end
            else
            begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 6);
            end
            set_size(CFG_W'(w), CFG_W'(h));
            case ($urandom_range(3))
                0:       dens = 10;
                1:       dens = 40;
                2:       dens = 75;
                default: dens = 100;
            endcase
            fill_random(eff_width() * eff_height(), dens);
            sent += eff_width() * eff_height() + eff_width() + 1;
            push_frame(30, 8);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 2 * MAX_W; i++)
            line_mem[i] = 8'd0;
        restart_frame();

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_neighbor_order();
        test_corner_seed();
        test_flush_rules();
        test_height_cut();
        test_random_frames();

        // Drain everything, then watch a while for stray results
        settle();
        repeat (20) @(posedge clk);

        $display("Covered %0d frames: %0d items accepted, %0d dilated pixels checked.",
                 frames_out, items_in, results_seen);
        $display("Sizes ran from 1x1 up to 80 wide, zero sizes clamped, one height cut.");
        if (bad_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
